### rtl/zlp_pkg.sv
// Shared types, codes and helper functions for the ziplist entry stream parser.
`timescale 1ns / 1ps
package zlp_pkg;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_PREV,
    PH_PREVSKIP,
    PH_ENC,
    PH_LEN14,
    PH_LEN32,
    PH_STR,
    PH_INT,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    KIND_STR_BYTE = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_INT      = 3'd2,
    KIND_END      = 3'd3,
    KIND_BAD      = 3'd4
  } kind_t;

  localparam logic [7:0] ENC_INT16 = 8'hc0;
  localparam logic [7:0] ENC_INT32 = 8'hd0;
  localparam logic [7:0] ENC_INT64 = 8'he0;
  localparam logic [7:0] ENC_INT24 = 8'hf0;
  localparam logic [7:0] ENC_INT8  = 8'hfe;
  localparam logic [7:0] END_MARK  = 8'hff;
  localparam logic [7:0] PREV_LONG = 8'hfe;

  localparam logic [3:0] HDR_CNT_LO     = 4'd8;
  localparam logic [3:0] HDR_CNT_HI     = 4'd9;
  localparam logic [3:0] PREV_EXT_BYTES = 4'd4;
  localparam logic [3:0] LEN32_BYTES    = 4'd4;

  localparam logic [31:0] CNT_CHECK_LIMIT = 32'h0000_fffe;

  // Payload byte count of a multi-byte integer encoding.
  function automatic logic [3:0] int_bytes(input logic [7:0] enc);
    logic [3:0] n;
    case (enc)
      ENC_INT16: n = 4'd2;
      ENC_INT32: n = 4'd4;
      ENC_INT64: n = 4'd8;
      ENC_INT24: n = 4'd3;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // Sign-extend a little-endian value of n bytes to 64 bits.
  function automatic logic [63:0] sign_ext(input logic [63:0] acc, input logic [3:0] n);
    logic [63:0] v;
    case (n)
      4'd1:    v = {{56{acc[7]}}, acc[7:0]};
      4'd2:    v = {{48{acc[15]}}, acc[15:0]};
      4'd3:    v = {{40{acc[23]}}, acc[23:0]};
      4'd4:    v = {{32{acc[31]}}, acc[31:0]};
      default: v = acc;
    endcase
    return v;
  endfunction

endpackage

### rtl/ziplist_entry_stream_parser_top.sv
// Ziplist entry stream parser: byte-wise header, entry and integer/string decoder.
// A result is registered: it is held in the output register in the cycle after its byte's transfer.
// Throughput: one byte per cycle while out_ready is high or out_valid low; the byte decode and
// state update sit in one combinational stage between the parse-state and output registers.
// A byte that gives no result never occupies the output register.
// Reset (rst, synchronous): clears pair mode and all parse state; parsing starts in the header.
`timescale 1ns / 1ps
module ziplist_entry_stream_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               pair_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [7:0]         data_byte,
  output logic signed [63:0] int_value,
  output logic [31:0]        str_length,
  output logic               last_of_entry,
  output logic               is_value,
  output logic [31:0]        entry_count,
  output logic               count_mismatch
);

  logic pair_en;

  zlp_pkg::phase_t phase, phase_next, cur_phase;
  logic [3:0]  byte_counter, byte_counter_next, cur_bc;
  logic [15:0] header_count, header_count_next, cur_hc;
  logic [7:0]  encoding_byte, encoding_byte_next, cur_enc;
  logic [31:0] remaining_length, remaining_length_next, cur_rem;
  logic [31:0] string_length, string_length_next, cur_slen;
  logic [63:0] int_accumulator, int_accumulator_next, cur_acc;
  logic [31:0] entries_seen, entries_seen_next, cur_seen;
  logic        key_value_toggle, key_value_toggle_next, cur_tog;

  logic in_fire;

  // decode helpers
  logic [3:0]  bc_inc;
  logic        enc_str6, enc_str14, enc_str32, enc_int, enc_imm;
  logic [31:0] len14_val, len32_val, rem_dec, seen_inc;
  logic [63:0] acc_merged;
  logic [3:0]  int_n;
  logic        int_done;

  // result of the current byte
  logic               res_fire;
  zlp_pkg::kind_t     res_kind;
  logic [7:0]         res_data;
  logic [63:0]        res_int;
  logic [31:0]        res_slen;
  logic               res_last;
  logic               res_mismatch;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // start_req clears the parse state before the byte is processed
  assign cur_phase = start_req ? zlp_pkg::PH_HDR : phase;
  assign cur_bc    = start_req ? 4'd0  : byte_counter;
  assign cur_hc    = start_req ? 16'd0 : header_count;
  assign cur_enc   = start_req ? 8'd0  : encoding_byte;
  assign cur_rem   = start_req ? 32'd0 : remaining_length;
  assign cur_slen  = start_req ? 32'd0 : string_length;
  assign cur_acc   = start_req ? 64'd0 : int_accumulator;
  assign cur_seen  = start_req ? 32'd0 : entries_seen;
  assign cur_tog   = start_req ? 1'b0  : key_value_toggle;

  assign bc_inc    = cur_bc + 4'd1;
  assign enc_str6  = (in_byte[7:6] == 2'b00);
  assign enc_str14 = (in_byte[7:6] == 2'b01);
  assign enc_str32 = (in_byte[7:6] == 2'b10);
  assign enc_int   = (in_byte == zlp_pkg::ENC_INT16) || (in_byte == zlp_pkg::ENC_INT32) ||
                     (in_byte == zlp_pkg::ENC_INT64) || (in_byte == zlp_pkg::ENC_INT24) ||
                     (in_byte == zlp_pkg::ENC_INT8);
  assign enc_imm   = (in_byte[7:4] == 4'hf) && (in_byte != zlp_pkg::END_MARK) && !enc_int;

  assign len14_val  = {18'd0, cur_slen[5:0], in_byte};
  assign len32_val  = {cur_slen[23:0], in_byte};
  assign rem_dec    = cur_rem - 32'd1;
  assign seen_inc   = (&cur_seen) ? cur_seen : cur_seen + 32'd1;
  assign acc_merged = cur_acc | ({56'd0, in_byte} << {cur_bc[2:0], 3'b000});
  assign int_n      = zlp_pkg::int_bytes(cur_enc);
  assign int_done   = (bc_inc >= int_n);

  // next parse state
  always_comb begin
    phase_next            = cur_phase;
    byte_counter_next     = cur_bc;
    header_count_next     = cur_hc;
    encoding_byte_next    = cur_enc;
    remaining_length_next = cur_rem;
    string_length_next    = cur_slen;
    int_accumulator_next  = cur_acc;
    entries_seen_next     = cur_seen;
    key_value_toggle_next = cur_tog;
    unique case (cur_phase)
      zlp_pkg::PH_HDR: begin
        if (cur_bc == zlp_pkg::HDR_CNT_LO) begin
          header_count_next[7:0] = in_byte;
        end else if (cur_bc == zlp_pkg::HDR_CNT_HI) begin
          header_count_next[15:8] = in_byte;
        end
        if (cur_bc >= zlp_pkg::HDR_CNT_HI) begin
          byte_counter_next = 4'd0;
          phase_next        = zlp_pkg::PH_PREV;
        end else begin
          byte_counter_next = bc_inc;
        end
      end
      zlp_pkg::PH_PREV: begin
        if (in_byte == zlp_pkg::END_MARK) begin
          phase_next = zlp_pkg::PH_DONE;
        end else if (in_byte == zlp_pkg::PREV_LONG) begin
          byte_counter_next = 4'd0;
          phase_next        = zlp_pkg::PH_PREVSKIP;
        end else begin
          phase_next = zlp_pkg::PH_ENC;
        end
      end
      zlp_pkg::PH_PREVSKIP: begin
        byte_counter_next = bc_inc;
        if (bc_inc >= zlp_pkg::PREV_EXT_BYTES) begin
          byte_counter_next = 4'd0;
          phase_next        = zlp_pkg::PH_ENC;
        end
      end
      zlp_pkg::PH_ENC: begin
        encoding_byte_next   = in_byte;
        byte_counter_next    = 4'd0;
        int_accumulator_next = 64'd0;
        if (enc_str6) begin
          string_length_next    = {26'd0, in_byte[5:0]};
          remaining_length_next = {26'd0, in_byte[5:0]};
          if (in_byte[5:0] == 6'd0) begin
            entries_seen_next     = seen_inc;
            key_value_toggle_next = !cur_tog;
            phase_next            = zlp_pkg::PH_PREV;
          end else begin
            phase_next = zlp_pkg::PH_STR;
          end
        end else if (enc_str14) begin
          string_length_next = {26'd0, in_byte[5:0]};
          phase_next         = zlp_pkg::PH_LEN14;
        end else if (enc_str32) begin
          string_length_next = 32'd0;
          phase_next         = zlp_pkg::PH_LEN32;
        end else if (enc_int) begin
          phase_next = zlp_pkg::PH_INT;
        end else if (enc_imm) begin
          entries_seen_next     = seen_inc;
          key_value_toggle_next = !cur_tog;
          phase_next            = zlp_pkg::PH_PREV;
        end else begin
          phase_next = zlp_pkg::PH_ERR;
        end
      end
      zlp_pkg::PH_LEN14: begin
        string_length_next    = len14_val;
        remaining_length_next = len14_val;
        if (len14_val == 32'd0) begin
          entries_seen_next     = seen_inc;
          key_value_toggle_next = !cur_tog;
          phase_next            = zlp_pkg::PH_PREV;
        end else begin
          phase_next = zlp_pkg::PH_STR;
        end
      end
      zlp_pkg::PH_LEN32: begin
        string_length_next = len32_val;
        byte_counter_next  = bc_inc;
        if (bc_inc >= zlp_pkg::LEN32_BYTES) begin
          byte_counter_next     = 4'd0;
          remaining_length_next = len32_val;
          if (len32_val == 32'd0) begin
            entries_seen_next     = seen_inc;
            key_value_toggle_next = !cur_tog;
            phase_next            = zlp_pkg::PH_PREV;
          end else begin
            phase_next = zlp_pkg::PH_STR;
          end
        end
      end
      zlp_pkg::PH_STR: begin
        remaining_length_next = rem_dec;
        if (rem_dec == 32'd0) begin
          entries_seen_next     = seen_inc;
          key_value_toggle_next = !cur_tog;
          phase_next            = zlp_pkg::PH_PREV;
        end
      end
      zlp_pkg::PH_INT: begin
        int_accumulator_next = acc_merged;
        byte_counter_next    = bc_inc;
        if (int_done) begin
          byte_counter_next     = 4'd0;
          entries_seen_next     = seen_inc;
          key_value_toggle_next = !cur_tog;
          phase_next            = zlp_pkg::PH_PREV;
        end
      end
      default: begin
        // end of list or bad encoding: drop bytes until the next start
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_fire     = 1'b0;
    res_kind     = zlp_pkg::KIND_BAD;
    res_data     = 8'd0;
    res_int      = 64'd0;
    res_slen     = 32'd0;
    res_last     = 1'b0;
    res_mismatch = 1'b0;
    unique case (cur_phase)
      zlp_pkg::PH_PREV: begin
        if (in_byte == zlp_pkg::END_MARK) begin
          res_fire     = 1'b1;
          res_kind     = zlp_pkg::KIND_END;
          res_mismatch = (cur_seen < zlp_pkg::CNT_CHECK_LIMIT) &&
                         (cur_seen != {16'd0, cur_hc});
        end
      end
      zlp_pkg::PH_ENC: begin
        if (enc_str6) begin
          if (in_byte[5:0] == 6'd0) begin
            res_fire = 1'b1;
            res_kind = zlp_pkg::KIND_EMPTY;
            res_last = 1'b1;
          end
        end else if (enc_str14 || enc_str32 || enc_int) begin
          res_fire = 1'b0;
        end else if (enc_imm) begin
          res_fire = 1'b1;
          res_kind = zlp_pkg::KIND_INT;
          res_int  = {60'd0, in_byte[3:0] - 4'd1};
          res_last = 1'b1;
        end else begin
          res_fire = 1'b1;
          res_kind = zlp_pkg::KIND_BAD;
        end
      end
      zlp_pkg::PH_LEN14: begin
        if (len14_val == 32'd0) begin
          res_fire = 1'b1;
          res_kind = zlp_pkg::KIND_EMPTY;
          res_last = 1'b1;
        end
      end
      zlp_pkg::PH_LEN32: begin
        if ((bc_inc >= zlp_pkg::LEN32_BYTES) && (len32_val == 32'd0)) begin
          res_fire = 1'b1;
          res_kind = zlp_pkg::KIND_EMPTY;
          res_last = 1'b1;
        end
      end
      zlp_pkg::PH_STR: begin
        res_fire = 1'b1;
        res_kind = zlp_pkg::KIND_STR_BYTE;
        res_data = in_byte;
        res_slen = cur_slen;
        res_last = (rem_dec == 32'd0);
      end
      zlp_pkg::PH_INT: begin
        if (int_done) begin
          res_fire = 1'b1;
          res_kind = zlp_pkg::KIND_INT;
          res_int  = zlp_pkg::sign_ext(acc_merged, int_n);
          res_last = 1'b1;
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pair_en <= pair_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= zlp_pkg::PH_HDR;
      byte_counter     <= 4'd0;
      header_count     <= 16'd0;
      encoding_byte    <= 8'd0;
      remaining_length <= 32'd0;
      string_length    <= 32'd0;
      int_accumulator  <= 64'd0;
      entries_seen     <= 32'd0;
      key_value_toggle <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      byte_counter     <= byte_counter_next;
      header_count     <= header_count_next;
      encoding_byte    <= encoding_byte_next;
      remaining_length <= remaining_length_next;
      string_length    <= string_length_next;
      int_accumulator  <= int_accumulator_next;
      entries_seen     <= entries_seen_next;
      key_value_toggle <= key_value_toggle_next;
    end
  end

  // output register: load on a transfer that yields a result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      kind           <= res_kind;
      data_byte      <= res_data;
      int_value      <= res_int;
      str_length     <= res_slen;
      last_of_entry  <= res_last;
      is_value       <= (res_kind == zlp_pkg::KIND_STR_BYTE || res_kind == zlp_pkg::KIND_EMPTY ||
                         res_kind == zlp_pkg::KIND_INT) ? (pair_en && cur_tog) : 1'b0;
      entry_count    <= cur_seen;
      count_mismatch <= res_mismatch;
    end
  end

`ifndef SYNTHESIS
  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_fire && res_kind == zlp_pkg::KIND_END) |=> (phase == zlp_pkg::PH_DONE))
    else $error("end of list did not stop the parser");

  a_bad_stops: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_fire && res_kind == zlp_pkg::KIND_BAD) |=> (phase == zlp_pkg::PH_ERR))
    else $error("bad encoding did not stop the parser");

  a_str_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == zlp_pkg::KIND_STR_BYTE) |-> (str_length != 32'd0))
    else $error("string byte with zero length");

  a_mismatch_end_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count_mismatch) |-> (kind == zlp_pkg::KIND_END))
    else $error("count mismatch outside end of list");

  a_int_enc: assert property (@(posedge clk) disable iff (rst)
    (phase == zlp_pkg::PH_INT) |->
      (encoding_byte == zlp_pkg::ENC_INT16 || encoding_byte == zlp_pkg::ENC_INT32 ||
       encoding_byte == zlp_pkg::ENC_INT64 || encoding_byte == zlp_pkg::ENC_INT24 ||
       encoding_byte == zlp_pkg::ENC_INT8))
    else $error("integer phase with non-integer encoding");
`endif

endmodule

### bench/ziplist_entry_stream_parser_top_test.sv
// Self-checking testbench for the ziplist entry stream parser: random ziplists, scoreboard.
`timescale 1ns / 1ps
module ziplist_entry_stream_parser_top_test;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [63:0] ival;
    logic [31:0] slen;
    logic        last;
    logic        is_val;
    logic [31:0] count;
    logic        mismatch;
  } parse_result_t;

  // Tracks the parse state of the byte stream and queues the results it must produce.
  class zl_scoreboard;
    parse_result_t   expected_q[$];
    logic            pair_on;
    zlp_pkg::phase_t stage;
    logic [3:0]      step_cnt;
    logic [15:0]     hdr_count;
    logic [7:0]      enc_byte;
    logic [31:0]     bytes_left;
    logic [31:0]     str_len;
    logic [31:0]     entries_done;
    logic [63:0]     int_acc;
    logic            value_turn;
    int              errors;
    int              checked;

    function new();
      pair_on = 1'b0;
      errors = 0;
      checked = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      stage = zlp_pkg::PH_HDR;
      step_cnt = '0;
      hdr_count = '0;
      enc_byte = '0;
      bytes_left = '0;
      str_len = '0;
      int_acc = '0;
      entries_done = '0;
      value_turn = 1'b0;
    endfunction

    function void push_result(logic [2:0] k, logic [7:0] d, logic [63:0] iv,
                              logic [31:0] sl, logic last, logic mism);
      parse_result_t r;
      r.kind = k;
      r.data = d;
      r.ival = iv;
      r.slen = sl;
      r.last = last;
      r.is_val = (k <= zlp_pkg::KIND_INT && pair_on) ? value_turn : 1'b0;
      r.count = entries_done;
      r.mismatch = mism;
      expected_q.push_back(r);
    endfunction

    function void close_entry();
      if (entries_done != 32'hffff_ffff) entries_done++;
      value_turn = ~value_turn;
      stage = zlp_pkg::PH_PREV;
    endfunction

    function void open_string();
      bytes_left = str_len;
      if (str_len == 0) begin
        push_result(zlp_pkg::KIND_EMPTY, 8'd0, 64'd0, 32'd0, 1'b1, 1'b0);
        close_entry();
      end else begin
        stage = zlp_pkg::PH_STR;
      end
    endfunction

    function void decode_encoding(logic [7:0] b);
      enc_byte = b;
      step_cnt = '0;
      int_acc = '0;
      case (b[7:6])
        2'b00: begin
          str_len = {26'd0, b[5:0]};
          open_string();
        end
        2'b01: begin
          str_len = {26'd0, b[5:0]};
          stage = zlp_pkg::PH_LEN14;
        end
        2'b10: begin
          str_len = '0;
          stage = zlp_pkg::PH_LEN32;
        end
        default: begin
          if (b == zlp_pkg::ENC_INT16 || b == zlp_pkg::ENC_INT32 ||
              b == zlp_pkg::ENC_INT64 || b == zlp_pkg::ENC_INT24 ||
              b == zlp_pkg::ENC_INT8) begin
            stage = zlp_pkg::PH_INT;
          end else if (b[7:4] == 4'hf && b != zlp_pkg::END_MARK) begin
            // immediate: nibble minus one
            push_result(zlp_pkg::KIND_INT, 8'd0, {60'd0, b[3:0]} - 64'd1, 32'd0, 1'b1, 1'b0);
            close_entry();
          end else begin
            push_result(zlp_pkg::KIND_BAD, 8'd0, 64'd0, 32'd0, 1'b0, 1'b0);
            stage = zlp_pkg::PH_ERR;
          end
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic sr);
      logic [3:0]  width;
      logic [63:0] v;
      if (sr) clear_parse();
      case (stage)
        zlp_pkg::PH_HDR: begin
          if (step_cnt == zlp_pkg::HDR_CNT_LO) hdr_count[7:0] = b;
          else if (step_cnt == zlp_pkg::HDR_CNT_HI) hdr_count[15:8] = b;
          if (step_cnt >= zlp_pkg::HDR_CNT_HI) begin
            step_cnt = '0;
            stage = zlp_pkg::PH_PREV;
          end else begin
            step_cnt++;
          end
        end
        zlp_pkg::PH_PREV: begin
          if (b == zlp_pkg::END_MARK) begin
            push_result(zlp_pkg::KIND_END, 8'd0, 64'd0, 32'd0, 1'b0,
                        entries_done < zlp_pkg::CNT_CHECK_LIMIT &&
                        entries_done != {16'd0, hdr_count});
            stage = zlp_pkg::PH_DONE;
          end else if (b == zlp_pkg::PREV_LONG) begin
            step_cnt = '0;
            stage = zlp_pkg::PH_PREVSKIP;
          end else begin
            stage = zlp_pkg::PH_ENC;
          end
        end
        zlp_pkg::PH_PREVSKIP: begin
          step_cnt++;
          if (step_cnt >= zlp_pkg::PREV_EXT_BYTES) begin
            step_cnt = '0;
            stage = zlp_pkg::PH_ENC;
          end
        end
        zlp_pkg::PH_ENC: decode_encoding(b);
        zlp_pkg::PH_LEN14: begin
          str_len = {18'd0, str_len[5:0], b};
          open_string();
        end
        zlp_pkg::PH_LEN32: begin
          str_len = {str_len[23:0], b};
          step_cnt++;
          if (step_cnt >= zlp_pkg::LEN32_BYTES) begin
            step_cnt = '0;
            open_string();
          end
        end
        zlp_pkg::PH_STR: begin
          bytes_left--;
          push_result(zlp_pkg::KIND_STR_BYTE, b, 64'd0, str_len, bytes_left == 0, 1'b0);
          if (bytes_left == 0) close_entry();
        end
        zlp_pkg::PH_INT: begin
          case (enc_byte)
            zlp_pkg::ENC_INT16: width = 4'd2;
            zlp_pkg::ENC_INT32: width = 4'd4;
            zlp_pkg::ENC_INT64: width = 4'd8;
            zlp_pkg::ENC_INT24: width = 4'd3;
            default:            width = 4'd1;
          endcase
          int_acc = int_acc | ({56'd0, b} << (8 * step_cnt[2:0]));
          step_cnt++;
          if (step_cnt >= width) begin
            v = int_acc;
            if (width < 8 && v[8 * width - 1]) v = v | (~64'd0 << (8 * width));
            push_result(zlp_pkg::KIND_INT, 8'd0, v, 32'd0, 1'b1, 1'b0);
            step_cnt = '0;
            close_entry();
          end
        end
        default: ;  // done or error: drop until next start
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h expected %h", checked, name, got, want));
    endtask

    task check_result(parse_result_t got);
      parse_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d kind %0d arrived with nothing expected", checked,
                         got.kind));
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("data_byte", 64'(got.data), 64'(want.data));
      compare_field("int_value", got.ival, want.ival);
      compare_field("str_length", 64'(got.slen), 64'(want.slen));
      compare_field("last_of_entry", 64'(got.last), 64'(want.last));
      compare_field("is_value", 64'(got.is_val), 64'(want.is_val));
      compare_field("entry_count", 64'(got.count), 64'(want.count));
      compare_field("count_mismatch", 64'(got.mismatch), 64'(want.mismatch));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               pair_mode;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte;
  logic               start_req;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         kind;
  logic [7:0]         data_byte;
  logic signed [63:0] int_value;
  logic [31:0]        str_length;
  logic               last_of_entry;
  logic               is_value;
  logic [31:0]        entry_count;
  logic               count_mismatch;

  zl_scoreboard sb;
  int burst_left = 0;
  int sent_bytes = 0;
  int ignored_bytes = 0;
  int lists_sent = 0;
  int noise_bursts = 0;
  int cfg_writes = 0;
  int holds_asked = 0;

  ziplist_entry_stream_parser_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .pair_mode(pair_mode),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .start_req(start_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .data_byte(data_byte),
    .int_value(int_value),
    .str_length(str_length),
    .last_of_entry(last_of_entry),
    .is_value(is_value),
    .entry_count(entry_count),
    .count_mismatch(count_mismatch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: ready pattern changes every so often; a requested hold blocks it for long.
  initial begin : receiver
    int holds_done;
    int hold_left;
    int rx_mode;
    int mode_left;
    int tick;
    holds_done = 0;
    hold_left = 0;
    rx_mode = 0;
    mode_left = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        tick++;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : watch_results
    parse_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.data = data_byte;
      got.ival = int_value;
      got.slen = str_length;
      got.last = last_of_entry;
      got.is_val = is_value;
      got.count = entry_count;
      got.mismatch = count_mismatch;
      sb.check_result(got);
    end
  end

  // Called and returns at a falling edge; keeps valid high across a burst.
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    start_req <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, s);
    burst_left--;
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_ignored(input int n);
    repeat (n) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      ignored_bytes++;
    end
  endtask

  function automatic logic [7:0] biased_byte();
    logic [7:0] corners[4];
    corners = '{8'h00, 8'h7f, 8'h80, 8'hff};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Let the output drain, then wait so nothing is in flight.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pair_mode(input logic v);
    cfg_valid <= 1'b1;
    pair_mode <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.pair_on = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One entry with random shape; cut is set when the list cannot continue.
  task automatic send_entry(output bit cut);
    int          pick;
    int          nbytes;
    int          fill;
    logic [7:0]  enc;
    logic [31:0] blen;
    cut = 1'b0;
    if ($urandom_range(0, 6) == 0) begin
      send_byte(zlp_pkg::PREV_LONG, 1'b0);
      repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 253)), 1'b0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 9) == 0) blen = 0;
      else if ($urandom_range(0, 19) == 0) blen = 63;
      else blen = $urandom_range(1, 10);
      send_byte({2'b00, blen[5:0]}, 1'b0);
      repeat (blen) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 38) begin
      if ($urandom_range(0, 7) == 0) begin
        cut = 1'b1;
        blen = $urandom_range(0, 1) ? 32'h3fff : $urandom_range(64, 16383);
      end else begin
        blen = $urandom_range(0, 24);
      end
      send_byte({2'b01, blen[13:8]}, 1'b0);
      send_byte(blen[7:0], 1'b0);
      nbytes = cut ? $urandom_range(1, 20) : blen;
      repeat (nbytes) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 48) begin
      // low six bits of this encoding carry nothing
      enc = {2'b10, 6'($urandom_range(0, 63))};
      if ($urandom_range(0, 5) == 0) begin
        cut = 1'b1;
        blen = $urandom_range(0, 1) ? 32'hffff_ffff : ($urandom() | 32'h100);
      end else begin
        blen = $urandom_range(0, 12);
      end
      send_byte(enc, 1'b0);
      send_byte(blen[31:24], 1'b0);
      send_byte(blen[23:16], 1'b0);
      send_byte(blen[15:8], 1'b0);
      send_byte(blen[7:0], 1'b0);
      nbytes = cut ? $urandom_range(1, 20) : blen;
      repeat (nbytes) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 78) begin
      case ($urandom_range(0, 4))
        0: begin enc = zlp_pkg::ENC_INT16; nbytes = 2; end
        1: begin enc = zlp_pkg::ENC_INT32; nbytes = 4; end
        2: begin enc = zlp_pkg::ENC_INT64; nbytes = 8; end
        3: begin enc = zlp_pkg::ENC_INT24; nbytes = 3; end
        default: begin enc = zlp_pkg::ENC_INT8; nbytes = 1; end
      endcase
      fill = $urandom_range(0, 5);
      send_byte(enc, 1'b0);
      for (int j = 0; j < nbytes; j++) begin
        // fill 0 gives the most negative value, fill 1 the most positive
        if (fill == 0) send_byte((j == nbytes - 1) ? 8'h80 : 8'h00, 1'b0);
        else if (fill == 1) send_byte((j == nbytes - 1) ? 8'h7f : 8'hff, 1'b0);
        else send_byte(biased_byte(), 1'b0);
      end
    end else if (pick < 94) begin
      send_byte(8'($urandom_range(8'hf1, 8'hfd)), 1'b0);
    end else begin
      case ($urandom_range(0, 3))
        0: enc = 8'($urandom_range(8'hc1, 8'hcf));
        1: enc = 8'($urandom_range(8'hd1, 8'hdf));
        2: enc = 8'($urandom_range(8'he1, 8'hef));
        default: enc = zlp_pkg::END_MARK;
      endcase
      send_byte(enc, 1'b0);
      send_ignored($urandom_range(0, 2));
      cut = 1'b1;
    end
  endtask

  task automatic send_list();
    int          n;
    logic [15:0] hcnt;
    logic [7:0]  b;
    bit          cut;
    n = $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0: hcnt = 16'($urandom_range(0, 65535));
      1: hcnt = $urandom_range(0, 1) ? 16'hffff : 16'hfffe;
      default: hcnt = 16'(n);
    endcase
    for (int i = 0; i < 10; i++) begin
      if (i == zlp_pkg::HDR_CNT_LO) b = hcnt[7:0];
      else if (i == zlp_pkg::HDR_CNT_HI) b = hcnt[15:8];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == 0);
    end
    cut = 1'b0;
    for (int i = 0; i < n && !cut; i++) send_entry(cut);
    if (!cut && $urandom_range(0, 9) != 0) begin
      send_byte(zlp_pkg::END_MARK, 1'b0);
      if ($urandom_range(0, 2) == 0) send_ignored($urandom_range(1, 3));
    end
    lists_sent++;
  endtask

  initial begin : stimulus
    logic [7:0] opening[24];
    logic       pm;
    int         waited;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    pair_mode = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'd0;
    start_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed list without a start marker: long prev field, both immediate extremes,
    // empty string, one string byte, and a header count that disagrees.
    write_pair_mode(1'b1);
    opening = '{8'h18, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00,
                8'hfe, 8'h12, 8'h00, 8'h00, 8'h00, 8'hf1,
                8'h00, 8'hfd,
                8'h06, 8'h00,
                8'h02, 8'h01, 8'h41,
                zlp_pkg::END_MARK};
    for (int i = 0; i < 24; i++) send_byte(opening[i], 1'b0);
    wait_quiet();
    write_pair_mode(1'b0);

    pm = 1'b0;
    while (sent_bytes - ignored_bytes < 1350) begin
      if (lists_sent % 8 == 7) begin
        wait_quiet();
        pm = ($urandom_range(0, 3) == 0) ? pm : ~pm;
        write_pair_mode(pm);
      end
      if (lists_sent == 5 || lists_sent == 30) holds_asked++;
      if ($urandom_range(0, 19) == 0) begin
        noise_bursts++;
        repeat ($urandom_range(3, 15))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      send_list();
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));

    $display("Sent %0d ziplists in %0d bytes (%0d ignored, %0d noise bursts), %0d config writes.",
             lists_sent, sent_bytes, ignored_bytes, noise_bursts, cfg_writes);
    $display("Checked %0d results; %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("ziplist_entry_stream_parser_top test passed");
    else
      $display("ziplist_entry_stream_parser_top test failed");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout: stimulus or results stalled.");
    $display("ziplist_entry_stream_parser_top test failed");
    $finish;
  end

endmodule
